// File: rtl/lsdrs_pkg.sv
// shared types, constants and helpers for the decimal lsd radix sorter
// no dependencies
package lsdrs_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int RADIX         = 10;
  localparam int CNT_W         = 7;
  localparam int PASS_W        = 4;
  localparam int MAX_PASSES    = 10;
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [31:0] value;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [31:0] sorted_value;
    logic        last_out;
    logic        overflow;
  } out_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] quot;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] addr;
    entry_t           data;
  } load_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [PASS_W-1:0] passes;
    logic              ovf;
  } job_t;

  typedef enum logic {
    FS_LOAD,
    FS_CLASSIFY
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_COUNT,
    BS_PREFIX,
    BS_DIST,
    BS_EMIT
  } back_state_t;

  function automatic logic [31:0] pow10(input logic [PASS_W-1:0] k);
    logic [31:0] r;
    unique case (k)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/lsdrs_front.sv
// load front end: stores incoming values, tracks max and overflow,
// then works out the decimal pass count. depends on lsdrs_pkg
module lsdrs_front #(
  parameter int MAX_ITEMS = lsdrs_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  lsdrs_pkg::in_t      in_data,
  input  logic                job_full,
  output logic                front_busy,
  output logic                job_push,
  output lsdrs_pkg::job_t     job,
  output lsdrs_pkg::load_wr_t load_wr
);
  import lsdrs_pkg::*;

  front_state_t      state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       max_r, max_nxt;
  logic              ovf_r, ovf_nxt;
  logic [PASS_W-1:0] k_r, k_nxt;
  logic              room;
  logic              done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_LOAD;
      cnt_r   <= '0;
      max_r   <= '0;
      ovf_r   <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      max_r   <= max_nxt;
      ovf_r   <= ovf_nxt;
      k_r     <= k_nxt;
    end
  end

  assign room = cnt_r < CNT_W'(MAX_ITEMS);
  assign done = (k_r == PASS_W'(MAX_PASSES)) || (max_r < pow10(k_r));

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    max_nxt         = max_r;
    ovf_nxt         = ovf_r;
    k_nxt           = k_r;
    job_push        = 1'b0;
    job.n           = cnt_r;
    job.passes      = k_r;
    job.ovf         = ovf_r;
    load_wr.we      = accept && room;
    load_wr.addr    = cnt_r;
    load_wr.data    = '{value: in_data.value, quot: in_data.value};
    front_busy      = (state_r == FS_CLASSIFY);
    unique case (state_r)
      FS_LOAD: begin
        if (accept) begin
          if (room) begin
            cnt_nxt = cnt_r + 1'b1;
            if (in_data.value > max_r) max_nxt = in_data.value;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_in) begin
            state_nxt = FS_CLASSIFY;
            k_nxt     = PASS_W'(1);
          end
        end
      end
      FS_CLASSIFY: begin
        if (done) begin
          if (!job_full) begin
            job_push  = 1'b1;
            cnt_nxt   = '0;
            max_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = FS_LOAD;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = FS_LOAD;
    endcase
  end

endmodule

// File: rtl/lsdrs_job_q.sv
// two-entry job queue between front and back
// depends on lsdrs_pkg
module lsdrs_job_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lsdrs_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            nonempty,
  output lsdrs_pkg::job_t head
);
  import lsdrs_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] fill_r, fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wp_r] <= push_job;
  end

  always_comb begin
    full     = (fill_r == 2'd2);
    nonempty = (fill_r != 2'd0);
    head     = slot_r[rp_r];
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    fill_nxt = fill_r;
    if (push && !full) begin
      wp_nxt   = ~wp_r;
      fill_nxt = fill_nxt + 1'b1;
    end
    if (pop && nonempty) begin
      rp_nxt   = ~rp_r;
      fill_nxt = fill_nxt - 1'b1;
    end
  end

endmodule

// File: rtl/lsdrs_back.sv
// sort engine: count, prefix and distribute passes over two ping-pong stores,
// then emits the sorted set. depends on lsdrs_pkg
module lsdrs_back #(
  parameter int MAX_ITEMS = lsdrs_pkg::MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lsdrs_pkg::load_wr_t load_wr,
  input  logic                job_valid,
  input  lsdrs_pkg::job_t     job,
  output logic                job_pop,
  output logic                back_busy,
  output logic                out_valid,
  output lsdrs_pkg::out_t     out_data
);
  import lsdrs_pkg::*;

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  entry_t mem_a [MAX_ITEMS];
  entry_t mem_b [MAX_ITEMS];
  entry_t rd_a_r, rd_b_r, rd;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [PASS_W-1:0] passes_r, passes_nxt;
  logic              ovf_r, ovf_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              v1_r, v2_r;
  logic [CNT_W-1:0]  idx1_r, idx2_r;
  logic [31:0]       val2_r, q2_r, qd2_r;
  logic [CNT_W-1:0]  cnt_r [RADIX];
  logic [CNT_W-1:0]  cnt_nxt [RADIX];
  logic [CNT_W-1:0]  start_r [RADIX];
  logic [CNT_W-1:0]  start_nxt [RADIX];
  logic [PASS_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              issue;
  logic              phase_done;
  logic [63:0]       prod;
  logic [31:0]       rem;
  logic [3:0]        dig;
  logic              dist_we;
  logic [AW-1:0]     dist_addr;
  logic              wa_en, wb_en;
  logic [AW-1:0]     wa_addr;

  assign rd   = pass_r[0] ? rd_b_r : rd_a_r;
  assign prod = rd.quot * RECIP10;
  assign rem  = q2_r - ((qd2_r << 3) + (qd2_r << 1));
  assign dig  = rem[3:0];

  assign issue      = ((state_r == BS_COUNT) || (state_r == BS_DIST) || (state_r == BS_EMIT))
                      && (iss_r < n_r);
  assign phase_done = (iss_r == n_r) && !v1_r && !v2_r;

  assign dist_we   = (state_r == BS_DIST) && v2_r;
  assign dist_addr = start_r[dig][AW-1:0];
  assign wa_en     = load_wr.we || (dist_we && pass_r[0]);
  assign wa_addr   = load_wr.we ? load_wr.addr[AW-1:0] : dist_addr;
  assign wb_en     = dist_we && !pass_r[0];

  always_ff @(posedge clk) begin
    if (wa_en) mem_a[wa_addr] <= load_wr.we ? load_wr.data
                                            : entry_t'{value: val2_r, quot: qd2_r};
    if (wb_en) mem_b[dist_addr] <= '{value: val2_r, quot: qd2_r};
    rd_a_r <= mem_a[iss_r[AW-1:0]];
    rd_b_r <= mem_b[iss_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    idx1_r <= iss_r;
    idx2_r <= idx1_r;
    val2_r <= rd.value;
    q2_r   <= rd.quot;
    qd2_r  <= {3'b000, prod[63:35]};
    n_r      <= n_nxt;
    passes_r <= passes_nxt;
    ovf_r    <= ovf_nxt;
    start_r  <= start_nxt;
    sum_r    <= sum_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      pass_r      <= '0;
      iss_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < RADIX; i++) cnt_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      iss_r       <= iss_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    passes_nxt    = passes_r;
    ovf_nxt       = ovf_r;
    pass_nxt      = pass_r;
    iss_nxt       = issue ? iss_r + 1'b1 : iss_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    k_nxt         = k_r;
    sum_nxt       = sum_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    job_pop       = 1'b0;
    unique case (state_r)
      BS_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          n_nxt      = job.n;
          passes_nxt = job.passes;
          ovf_nxt    = job.ovf;
          pass_nxt   = '0;
          iss_nxt    = '0;
          for (int i = 0; i < RADIX; i++) cnt_nxt[i] = '0;
          state_nxt  = BS_COUNT;
        end
      end
      BS_COUNT: begin
        if (v2_r) cnt_nxt[dig] = cnt_r[dig] + 1'b1;
        if (phase_done) begin
          k_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = BS_PREFIX;
        end
      end
      BS_PREFIX: begin
        start_nxt[k_r] = sum_r;
        sum_nxt        = sum_r + cnt_r[k_r];
        k_nxt          = k_r + 1'b1;
        if (k_r == PASS_W'(RADIX - 1)) begin
          iss_nxt   = '0;
          state_nxt = BS_DIST;
        end
      end
      BS_DIST: begin
        if (v2_r) start_nxt[dig] = start_r[dig] + 1'b1;
        if (phase_done) begin
          pass_nxt = pass_r + 1'b1;
          iss_nxt  = '0;
          if (pass_r + 1'b1 == passes_r) begin
            state_nxt = BS_EMIT;
          end else begin
            for (int i = 0; i < RADIX; i++) cnt_nxt[i] = '0;
            state_nxt = BS_COUNT;
          end
        end
      end
      BS_EMIT: begin
        if (v2_r) begin
          out_valid_nxt        = 1'b1;
          out_nxt.sorted_value = val2_r;
          out_nxt.last_out     = (idx2_r == n_r - 1'b1);
          out_nxt.overflow     = ovf_r;
        end
        if (phase_done) state_nxt = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  assign back_busy = (state_r != BS_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/decimal_lsd_radix_sorter_unit.sv
// top level of the decimal lsd radix sorter
// depends on lsdrs_pkg, lsdrs_front, lsdrs_job_q, lsdrs_back
//
// usage: present a value on in_data with start high; it is taken on a clock
// edge where busy is low. in_data.last_in ends the set. values past MAX_ITEMS
// are dropped and every result of that set carries overflow.
// after the last value busy stays high while the set is sorted and emitted:
// the pass count is found from the maximum, then each decimal pass runs a
// count sweep, a ten-step prefix and a distribute sweep, each sweep reading
// the store once per cycle, and then the sorted set is output.
// results come out one per cycle with out_valid high for one cycle each, in
// ascending order, last_out on the final one; the receiver cannot stall.
// while loading, a value is taken every cycle.
// reset clears all control state; the value stores need no clearing.
module decimal_lsd_radix_sorter_unit #(
  parameter int MAX_ITEMS = lsdrs_pkg::MAX_ITEMS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lsdrs_pkg::in_t  in_data,
  output logic            out_valid,
  output lsdrs_pkg::out_t out_data
);
  import lsdrs_pkg::*;

  logic     accept;
  logic     front_busy, back_busy;
  logic     job_push, job_pop, job_full, job_valid;
  job_t     job_in, job_head;
  load_wr_t load_wr;

  assign busy   = front_busy || job_valid || back_busy;
  assign accept = start && !busy;

  lsdrs_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_data    (in_data),
    .job_full   (job_full),
    .front_busy (front_busy),
    .job_push   (job_push),
    .job        (job_in),
    .load_wr    (load_wr)
  );

  lsdrs_job_q u_job_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (job_pop),
    .full     (job_full),
    .nonempty (job_valid),
    .head     (job_head)
  );

  lsdrs_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_wr   (load_wr),
    .job_valid (job_valid),
    .job       (job_head),
    .job_pop   (job_pop),
    .back_busy (back_busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/decimal_lsd_radix_sorter_unit_test.sv
// self-checking test of the decimal lsd radix sorter: sets of values are loaded,
// the sorted order is predicted and compared with every emitted transaction
// depends on lsdrs_pkg and decimal_lsd_radix_sorter_unit
module decimal_lsd_radix_sorter_unit_test;
  import lsdrs_pkg::*;

  localparam int CAP = MAX_ITEMS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  in_t pending_q[$];
  int gap_q[$];
  out_t sorted_q[$];
  logic [31:0] set_vals[$];
  logic set_ovf;
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit drain_req = 1'b0;

  decimal_lsd_radix_sorter_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // stable lsd sort, same digit passes as the block
  task automatic predict_sort(input in_t item);
    logic [31:0] src[$];
    logic [31:0] dst[$];
    logic [31:0] top;
    logic [63:0] lim;
    logic [31:0] div;
    int passes;
    out_t r;
    if (set_vals.size() < CAP) set_vals.push_back(item.value);
    else set_ovf = 1'b1;
    if (!item.last_in) return;
    src = set_vals;
    top = 0;
    foreach (src[i]) if (src[i] > top) top = src[i];
    passes = 1;
    lim = 10;
    while ({32'd0, top} >= lim) begin
      lim = lim * 10;
      passes++;
    end
    div = 1;
    for (int p = 0; p < passes; p++) begin
      dst.delete();
      for (int d = 0; d < RADIX; d++)
        foreach (src[i]) if ((src[i] / div) % RADIX == d) dst.push_back(src[i]);
      src = dst;
      div = div * 10;
    end
    foreach (src[i]) begin
      r.sorted_value = src[i];
      r.last_out = (i == src.size() - 1);
      r.overflow = set_ovf;
      sorted_q.push_back(r);
    end
    set_vals.delete();
    set_ovf = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(0, 999);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      3: return $urandom_range(999999990, 1000000010);
      default: return $urandom();
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_set(input logic [31:0] vals[$]);
    in_t it;
    foreach (vals[i]) begin
      it.value = vals[i];
      it.last_in = (i == vals.size() - 1);
      pending_q.push_back(it);
      gap_q.push_back(rand_gap());
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_sort(in_data);
        void'(pending_q.pop_front());
        gap_left = gap_q.pop_front();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() > 0 && !(drain_req && sorted_q.size() > 0)) begin
          in_data <= pending_q[0];
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected transaction value %0h", out_data.sorted_value);
          errors++;
        end else begin
          out_t e;
          e = sorted_q.pop_front();
          if (e.sorted_value !== out_data.sorted_value) begin
            $error("sorted_value expected %0d actual %0d", e.sorted_value, out_data.sorted_value);
            errors++;
          end
          if (e.last_out !== out_data.last_out) begin
            $error("last_out expected %0b actual %0b", e.last_out, out_data.last_out);
            errors++;
          end
          if (e.overflow !== out_data.overflow) begin
            $error("overflow expected %0b actual %0b", e.overflow, out_data.overflow);
            errors++;
          end
        end
      end
      if (out_valid || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] v[$];
    int n;
    set_vals.delete();
    set_ovf = 1'b0;
    // directed: single value, zero, extremes, duplicates
    v = {32'd0}; add_set(v);
    v = {32'hFFFF_FFFF}; add_set(v);
    v = {32'd5, 32'd3, 32'd5, 32'd0}; add_set(v);
    v = {32'hFFFF_FFFF, 32'd0, 32'd1000000000, 32'd999999999, 32'd10, 32'd9};
    add_set(v);
    v = {32'hAAAA_AAAA, 32'h5555_5555, 32'd42}; add_set(v);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // overflow including a dropped last value, then a full store
    v.delete();
    for (int i = 0; i < CAP + 3; i++) v.push_back(rand_value());
    add_set(v);
    v.delete();
    for (int i = 0; i < CAP; i++) v.push_back($urandom_range(0, 99));
    add_set(v);
    n = pending_q.size();
    while (n < 170) begin
      int k;
      k = $urandom_range(1, 8);
      v.delete();
      for (int i = 0; i < k; i++) v.push_back(rand_value());
      if (n > 155 && !drain_req) begin
        wait (pending_q.size() == 0);
        drain_req = 1'b1;
      end
      add_set(v);
      n += k;
    end
    wait (pending_q.size() == 0 && !start);
    wait (sorted_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/lsdrs_pkg.sv
rtl/lsdrs_front.sv
rtl/lsdrs_job_q.sv
rtl/lsdrs_back.sv
rtl/decimal_lsd_radix_sorter_unit.sv
tb/sv/decimal_lsd_radix_sorter_unit_test.sv
